FILE: src/cau_pkg.sv
// Shared types, constants and helpers for the complex arithmetic unit.
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = 2 * DATA_WIDTH + 1;
    localparam int QUO_W      = DATA_WIDTH + 1;
    localparam int REM_W      = SUM_W + FRAC_BITS + QUO_W;
    localparam int QCNT       = 2;

    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CONJ = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NEG  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZ = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_CONJ,
        OP_NEG,
        OP_NONE,
        OP_DIVZ
    } op_t;

    typedef struct packed {
        op_t                           op;
        logic signed [DATA_WIDTH-1:0]  a_re;
        logic signed [DATA_WIDTH-1:0]  a_im;
        logic signed [DATA_WIDTH-1:0]  b_re;
        logic signed [DATA_WIDTH-1:0]  b_im;
    } item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] val;
        logic                         sat;
    } clip_t;

    function automatic clip_t sat_clip(input logic signed [SUM_W-1:0] v);
        clip_t                   r;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
        lo = ~hi;
        r.sat = 1'b0;
        r.val = v[DATA_WIDTH-1:0];
        if (v > hi)
        begin
            r.val = hi[DATA_WIDTH-1:0];
            r.sat = 1'b1;
        end
        if (v < lo)
        begin
            r.val = lo[DATA_WIDTH-1:0];
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: src/cau_front.sv
// Front end: input beat register and operation classification.
module cau_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cau_pkg::MODE_W-1:0]         mode,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_re,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_im,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_re,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_im,
    output logic                               push,
    output cau_pkg::item_t                     push_item,
    input  logic                               q_full
);

    logic           valid_reg;
    logic           valid_next;
    cau_pkg::item_t item_reg;
    cau_pkg::op_t   op_cls;
    logic           take;

    always_comb
    begin
        case (mode)
            cau_pkg::MODE_ADD:  op_cls = cau_pkg::OP_ADD;
            cau_pkg::MODE_SUB:  op_cls = cau_pkg::OP_SUB;
            cau_pkg::MODE_MUL:  op_cls = cau_pkg::OP_MUL;
            cau_pkg::MODE_DIV:  op_cls = (b_re == '0 && b_im == '0) ?
                                         cau_pkg::OP_DIVZ : cau_pkg::OP_DIV;
            cau_pkg::MODE_CONJ: op_cls = cau_pkg::OP_CONJ;
            cau_pkg::MODE_NEG:  op_cls = cau_pkg::OP_NEG;
            default:            op_cls = cau_pkg::OP_NONE;
        endcase
    end

    assign push      = valid_reg && !q_full;
    assign push_item = item_reg;
    assign in_ready  = !valid_reg || push;
    assign take      = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op   <= op_cls;
            item_reg.a_re <= a_re;
            item_reg.a_im <= a_im;
            item_reg.b_re <= b_re;
            item_reg.b_im <= b_im;
        end
    end

endmodule

FILE: src/cau_queue.sv
// Two-entry queue between the front end and the execution pipeline.
module cau_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cau_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output cau_pkg::item_t q_item
);

    cau_pkg::item_t mem_reg [cau_pkg::QCNT];
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           wptr_reg;
    logic           rptr_reg;
    logic           do_pop;

    assign full    = (cnt_reg == 2'(cau_pkg::QCNT));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/cau_back.sv
// Execution pipeline: products, sums, bit-per-stage divider and saturation.
module cau_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  cau_pkg::item_t                        q_item,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] res_re,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] res_im,
    output logic [cau_pkg::STATUS_W-1:0]          status
);

    localparam int DW = cau_pkg::DATA_WIDTH;
    localparam int PW = cau_pkg::PROD_W;
    localparam int SW = cau_pkg::SUM_W;
    localparam int QW = cau_pkg::QUO_W;
    localparam int RW = cau_pkg::REM_W;

    typedef struct packed {
        cau_pkg::op_t          op;
        logic signed [PW-1:0]  p_rr;
        logic signed [PW-1:0]  p_ii;
        logic signed [PW-1:0]  p_ri;
        logic signed [PW-1:0]  p_ir;
        logic signed [PW-1:0]  p_bb;
        logic signed [PW-1:0]  p_cc;
        logic signed [DW:0]    s_re;
        logic signed [DW:0]    s_im;
    } s1_t;

    typedef struct packed {
        cau_pkg::op_t          op;
        logic signed [DW-1:0]  re;
        logic signed [DW-1:0]  im;
        logic                  sat;
        logic                  neg_re;
        logic                  neg_im;
        logic                  ovf_re;
        logic                  ovf_im;
        logic [RW-1:0]         rem_re;
        logic [RW-1:0]         rem_im;
        logic [QW-1:0]         q_re;
        logic [QW-1:0]         q_im;
        logic [PW-1:0]         den;
    } dv_t;

    logic                 adv;
    logic                 s1_valid_reg;
    s1_t                  s1_reg;
    s1_t                  s1_next;
    logic                 dv_valid_reg [QW+1];
    dv_t                  dv_reg [QW+1];
    dv_t                  dv_next [QW+1];
    logic                 out_valid_reg;
    logic signed [DW-1:0] re_reg;
    logic signed [DW-1:0] im_reg;
    logic [cau_pkg::STATUS_W-1:0] st_reg;
    logic signed [DW-1:0] re_next;
    logic signed [DW-1:0] im_next;
    logic [cau_pkg::STATUS_W-1:0] st_next;

    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv;
    assign out_valid = out_valid_reg;
    assign res_re    = re_reg;
    assign res_im    = im_reg;
    assign status    = st_reg;

    always_comb
    begin
        s1_next.op   = q_item.op;
        s1_next.p_rr = q_item.a_re * q_item.b_re;
        s1_next.p_ii = q_item.a_im * q_item.b_im;
        s1_next.p_ri = q_item.a_re * q_item.b_im;
        s1_next.p_ir = q_item.a_im * q_item.b_re;
        s1_next.p_bb = q_item.b_re * q_item.b_re;
        s1_next.p_cc = q_item.b_im * q_item.b_im;
        case (q_item.op)
            cau_pkg::OP_ADD:
            begin
                s1_next.s_re = (DW+1)'(q_item.a_re) + (DW+1)'(q_item.b_re);
                s1_next.s_im = (DW+1)'(q_item.a_im) + (DW+1)'(q_item.b_im);
            end
            cau_pkg::OP_SUB:
            begin
                s1_next.s_re = (DW+1)'(q_item.a_re) - (DW+1)'(q_item.b_re);
                s1_next.s_im = (DW+1)'(q_item.a_im) - (DW+1)'(q_item.b_im);
            end
            cau_pkg::OP_CONJ:
            begin
                s1_next.s_re = (DW+1)'(q_item.a_re);
                s1_next.s_im = -(DW+1)'(q_item.a_im);
            end
            cau_pkg::OP_NEG:
            begin
                s1_next.s_re = -(DW+1)'(q_item.a_re);
                s1_next.s_im = -(DW+1)'(q_item.a_im);
            end
            default:
            begin
                s1_next.s_re = '0;
                s1_next.s_im = '0;
            end
        endcase
    end

    always_comb
    begin
        logic signed [SW-1:0] m_re;
        logic signed [SW-1:0] m_im;
        logic signed [SW-1:0] n_re;
        logic signed [SW-1:0] n_im;
        logic [SW-1:0]        mag_re;
        logic [SW-1:0]        mag_im;
        logic [RW-1:0]        lim;
        cau_pkg::clip_t       c_re;
        cau_pkg::clip_t       c_im;
        m_re = (SW'(s1_reg.p_rr) - SW'(s1_reg.p_ii)) >>> cau_pkg::FRAC_BITS;
        m_im = (SW'(s1_reg.p_ri) + SW'(s1_reg.p_ir)) >>> cau_pkg::FRAC_BITS;
        n_re = SW'(s1_reg.p_rr) + SW'(s1_reg.p_ii);
        n_im = SW'(s1_reg.p_ir) - SW'(s1_reg.p_ri);
        mag_re = n_re[SW-1] ? SW'(-n_re) : SW'(n_re);
        mag_im = n_im[SW-1] ? SW'(-n_im) : SW'(n_im);
        if (s1_reg.op == cau_pkg::OP_MUL)
        begin
            c_re = cau_pkg::sat_clip(m_re);
            c_im = cau_pkg::sat_clip(m_im);
        end
        else
        begin
            c_re = cau_pkg::sat_clip(SW'(s1_reg.s_re));
            c_im = cau_pkg::sat_clip(SW'(s1_reg.s_im));
        end
        dv_next[0].op     = s1_reg.op;
        dv_next[0].re     = c_re.val;
        dv_next[0].im     = c_im.val;
        dv_next[0].sat    = c_re.sat || c_im.sat;
        dv_next[0].neg_re = n_re[SW-1];
        dv_next[0].neg_im = n_im[SW-1];
        dv_next[0].den    = PW'(s1_reg.p_bb) + PW'(s1_reg.p_cc);
        dv_next[0].rem_re = RW'(mag_re) << cau_pkg::FRAC_BITS;
        dv_next[0].rem_im = RW'(mag_im) << cau_pkg::FRAC_BITS;
        lim               = RW'(dv_next[0].den) << QW;
        dv_next[0].ovf_re = dv_next[0].rem_re >= lim;
        dv_next[0].ovf_im = dv_next[0].rem_im >= lim;
        dv_next[0].q_re   = '0;
        dv_next[0].q_im   = '0;
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        always_comb
        begin
            logic [RW-1:0] sh;
            sh = RW'(dv_reg[j].den) << (QW - 1 - j);
            dv_next[j+1] = dv_reg[j];
            if (dv_reg[j].rem_re >= sh)
            begin
                dv_next[j+1].rem_re = dv_reg[j].rem_re - sh;
                dv_next[j+1].q_re[QW-1-j] = 1'b1;
            end
            if (dv_reg[j].rem_im >= sh)
            begin
                dv_next[j+1].rem_im = dv_reg[j].rem_im - sh;
                dv_next[j+1].q_im[QW-1-j] = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [QW-1:0] half;
        logic          sr;
        logic          si;
        dv_t           d;
        d    = dv_reg[QW];
        half = QW'(1) << (DW - 1);
        sr   = d.ovf_re || (d.neg_re ? (d.q_re > half) : (d.q_re > half - QW'(1)));
        si   = d.ovf_im || (d.neg_im ? (d.q_im > half) : (d.q_im > half - QW'(1)));
        re_next = d.re;
        im_next = d.im;
        st_next = d.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        case (d.op)
            cau_pkg::OP_DIV:
            begin
                if (sr)
                begin
                    re_next = d.neg_re ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                end
                else
                begin
                    re_next = d.neg_re ? DW'(-d.q_re) : DW'(d.q_re);
                end
                if (si)
                begin
                    im_next = d.neg_im ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                end
                else
                begin
                    im_next = d.neg_im ? DW'(-d.q_im) : DW'(d.q_im);
                end
                st_next = (sr || si) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            cau_pkg::OP_DIVZ:
            begin
                re_next = '0;
                im_next = '0;
                st_next = cau_pkg::ST_DIVZ;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= QW; k++)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg    <= q_valid;
            dv_valid_reg[0] <= s1_valid_reg;
            for (int k = 1; k <= QW; k++)
            begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
            out_valid_reg <= dv_valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            for (int k = 0; k <= QW; k++)
            begin
                dv_reg[k] <= dv_next[k];
            end
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

endmodule

FILE: src/complex_arithmetic_unit.sv
// Input beat to result beat passes front, queue and 20 stages in the back end.
// Throughput: one beat per cycle unless stalled; one quotient bit per divider stage.
// All modes share one fixed-depth pipeline; a stalled output holds the whole pipe.
// Reset: rst_n clears all valid flags and queue pointers; no clearing pass.
// Top level of the complex arithmetic unit.
module complex_arithmetic_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [cau_pkg::MODE_W-1:0]            mode,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_re,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_im,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_re,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_im,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] res_re,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] res_im,
    output logic [cau_pkg::STATUS_W-1:0]          status
);

    logic           push;
    cau_pkg::item_t push_item;
    logic           q_full;
    logic           pop;
    logic           q_valid;
    cau_pkg::item_t q_item;

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    cau_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_re    (res_re),
        .res_im    (res_im),
        .status    (status)
    );

endmodule
